// File: rtl/lcsl_pkg.sv
package lcsl_pkg;

  localparam int unsigned IdW   = 31;
  localparam int unsigned LenW  = 9;
  localparam int unsigned TrajW = 16;

  localparam logic [TrajW-1:0] TrajMax = '1;

  localparam logic KindRef  = 1'b0;
  localparam logic KindTraj = 1'b1;

  typedef struct packed {
    logic           kind;
    logic [IdW-1:0] node_id;
    logic           last;
  } in_word_t;

  typedef struct packed {
    logic [LenW-1:0]  lcs_length;
    logic [LenW-1:0]  reference_count;
    logic [TrajW-1:0] trajectory_count;
    logic             overflow;
  } out_word_t;

endpackage

// File: rtl/lcsl_ram.sv
module lcsl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// File: rtl/lcs_length_via_lis.sv
// Longest common subsequence length of a reference ID sequence and a trajectory ID
// sequence, found as the strict longest increasing subsequence of matching reference
// positions. A reference word (kind 0) is appended to the reference memory, or
// dropped with the overflow flag set once MAX_REFERENCE are stored. A trajectory
// word (kind 1) walks the stored positions from the highest down: a reference memory
// read and a compare per position, and for every match a binary search over the tail
// memory with a read and a compare per probe (at most log2(T)+1 probes with T tails),
// a final bound check and a write step. The input is stalled while a word is
// processed. A word with last set passes through a report state, yields one result
// word (LCS length, both counts, overflow) and clears all counts; the result waits in
// the output register without blocking the next input, but a second report stalls
// until the first result word has been taken.
module lcs_length_via_lis #(
  parameter int unsigned MAX_REFERENCE = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lcsl_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lcsl_pkg::out_word_t out_word_o
);

  import lcsl_pkg::*;

  localparam int unsigned AW = $clog2(MAX_REFERENCE);
  localparam int unsigned CW = $clog2(MAX_REFERENCE + 1);
  localparam logic [CW-1:0] MaxCount = CW'(MAX_REFERENCE);

  typedef enum logic [6:0] {
    StIdle    = 7'b0000001,
    StScanRd  = 7'b0000010,
    StScanCmp = 7'b0000100,
    StBsRd    = 7'b0001000,
    StBsCmp   = 7'b0010000,
    StPlace   = 7'b0100000,
    StReport  = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [CW-1:0]    stored_count_q, stored_count_d;
  logic [CW-1:0]    tail_count_q, tail_count_d;
  logic [TrajW-1:0] seen_count_q, seen_count_d;
  logic             overflow_q, overflow_d;
  logic             out_valid_q, out_valid_d;
  logic             last_q, last_d;
  out_word_t        out_word_q, out_word_d;
  logic [AW-1:0]    pos_q, pos_d;
  logic [IdW-1:0]   id_q, id_d;
  logic [CW-1:0]    lo_q, lo_d;
  logic [CW-1:0]    hi_q, hi_d;

  logic             in_accept;
  logic [CW-1:0]    mid;
  logic             ref_we;
  logic [AW-1:0]    ref_addr;
  logic [IdW-1:0]   ref_rdata;
  logic             tail_we;
  logic [AW-1:0]    tail_addr;
  logic [AW-1:0]    tail_rdata;
  logic [31:0]      tail_count_ext;
  logic [31:0]      stored_count_ext;
  logic             out_free;

  assign in_stall_o  = (state_q != StIdle);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign mid = lo_q + ((hi_q - lo_q) >> 1);

  assign ref_we   = in_accept && (in_word_i.kind == KindRef) && (stored_count_q != MaxCount);
  assign ref_addr = (state_q == StIdle) ? stored_count_q[AW-1:0] : pos_q;

  // The tail index equals the tail count when the position extends the list.
  assign tail_we   = (state_q == StPlace) && ((lo_q < tail_count_q) || (tail_count_q != MaxCount));
  assign tail_addr = (state_q == StPlace) ? lo_q[AW-1:0] : mid[AW-1:0];

  assign tail_count_ext   = 32'(tail_count_q);
  assign stored_count_ext = 32'(stored_count_q);

  lcsl_ram #(
    .Width(IdW),
    .Depth(MAX_REFERENCE)
  ) u_ref_ram (
    .clk_i  (clk_i),
    .we_i   (ref_we),
    .addr_i (ref_addr),
    .wdata_i(in_word_i.node_id),
    .rdata_o(ref_rdata)
  );

  lcsl_ram #(
    .Width(AW),
    .Depth(MAX_REFERENCE)
  ) u_tail_ram (
    .clk_i  (clk_i),
    .we_i   (tail_we),
    .addr_i (tail_addr),
    .wdata_i(pos_q),
    .rdata_o(tail_rdata)
  );

  always_comb begin
    state_d        = state_q;
    stored_count_d = stored_count_q;
    tail_count_d   = tail_count_q;
    seen_count_d   = seen_count_q;
    overflow_d     = overflow_q;
    out_valid_d    = out_valid_q;
    last_d         = last_q;
    out_word_d     = out_word_q;
    pos_d          = pos_q;
    id_d           = id_q;
    lo_d           = lo_q;
    hi_d           = hi_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          last_d = in_word_i.last;
          id_d   = in_word_i.node_id;
          if (in_word_i.kind == KindRef) begin
            if (stored_count_q != MaxCount) begin
              stored_count_d = stored_count_q + CW'(1);
            end else begin
              overflow_d = 1'b1;
            end
            state_d = in_word_i.last ? StReport : StIdle;
          end else begin
            if (seen_count_q != TrajMax) begin
              seen_count_d = seen_count_q + TrajW'(1);
            end
            if (stored_count_q == '0) begin
              state_d = in_word_i.last ? StReport : StIdle;
            end else begin
              pos_d   = AW'(stored_count_q - CW'(1));
              state_d = StScanRd;
            end
          end
        end
      end
      StScanRd: begin
        state_d = StScanCmp;
      end
      StScanCmp: begin
        if (ref_rdata == id_q) begin
          lo_d    = '0;
          hi_d    = tail_count_q;
          state_d = StBsRd;
        end else if (pos_q == '0) begin
          state_d = last_q ? StReport : StIdle;
        end else begin
          pos_d   = pos_q - AW'(1);
          state_d = StScanRd;
        end
      end
      StBsRd: begin
        state_d = (lo_q < hi_q) ? StBsCmp : StPlace;
      end
      StBsCmp: begin
        if (tail_rdata < pos_q) begin
          lo_d = mid + CW'(1);
        end else begin
          hi_d = mid;
        end
        state_d = StBsRd;
      end
      StPlace: begin
        if (!(lo_q < tail_count_q) && (tail_count_q != MaxCount)) begin
          tail_count_d = tail_count_q + CW'(1);
        end
        if (pos_q == '0) begin
          state_d = last_q ? StReport : StIdle;
        end else begin
          pos_d   = pos_q - AW'(1);
          state_d = StScanRd;
        end
      end
      StReport: begin
        if (out_free) begin
          out_valid_d                = 1'b1;
          out_word_d.lcs_length       = tail_count_ext[LenW-1:0];
          out_word_d.reference_count  = stored_count_ext[LenW-1:0];
          out_word_d.trajectory_count = seen_count_q;
          out_word_d.overflow         = overflow_q;
          stored_count_d             = '0;
          tail_count_d               = '0;
          seen_count_d               = '0;
          overflow_d                 = 1'b0;
          state_d                    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      stored_count_q <= '0;
      tail_count_q   <= '0;
      seen_count_q   <= '0;
      overflow_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      last_q         <= 1'b0;
    end else begin
      state_q        <= state_d;
      stored_count_q <= stored_count_d;
      tail_count_q   <= tail_count_d;
      seen_count_q   <= seen_count_d;
      overflow_q     <= overflow_d;
      out_valid_q    <= out_valid_d;
      last_q         <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
    pos_q      <= pos_d;
    id_q       <= id_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
  end

endmodule

// File: rtl/lcsl_checker.sv
module lcsl_checker #(
  parameter int unsigned MAX_REFERENCE = 256
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input lcsl_pkg::in_word_t  in_word_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input lcsl_pkg::out_word_t out_word_o
);

  import lcsl_pkg::*;

  localparam logic Unmasked = (MAX_REFERENCE < 512);
  localparam logic [LenW-1:0] FullCount = LenW'(MAX_REFERENCE);

  // A stalled result word must stay put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word dropped or changed while stalled");

  // A word with last set always leads to a report, so the input stalls right after it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_word_i.last |=> in_stall_o)
    else $error("input not stalled after a word with last set");

  // Each trajectory word adds at most one element to a strictly increasing chain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    Unmasked && out_valid_o |->
      (16'(out_word_o.lcs_length) <= out_word_o.trajectory_count))
    else $error("LCS length exceeds trajectory count");

  // The LCS can never be longer than the reference sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    Unmasked && out_valid_o |->
      (out_word_o.lcs_length <= out_word_o.reference_count))
    else $error("LCS length exceeds reference count");

  // Words are only dropped once the reference store is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.overflow |-> (out_word_o.reference_count == FullCount))
    else $error("overflow reported with a store that is not full");

endmodule

bind lcs_length_via_lis lcsl_checker #(
  .MAX_REFERENCE(MAX_REFERENCE)
) u_lcsl_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_word_i  (in_word_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_word_o (out_word_o)
);

// File: verif/tb_lcs_length_via_lis.sv
module tb_lcs_length_via_lis;
  timeunit 1ns;
  timeprecision 1ps;

  import lcsl_pkg::*;

  localparam int unsigned MaxRoute   = 256;
  localparam int unsigned StallLimit = 40000;
  localparam int unsigned DrainWait  = 600;
  localparam int unsigned MaxPrinted = 30;
  localparam logic [IdW-1:0] IdMax   = '1;

  typedef struct {
    in_word_t    word;
    int unsigned gap;
  } pending_word_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  lcs_length_via_lis #(
    .MAX_REFERENCE(MaxRoute)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Predictor state: the stored reference route and the patience-sorting tails.
  logic [IdW-1:0] route_ids [MaxRoute];
  int unsigned    tails [MaxRoute];
  int unsigned    tail_len;
  int unsigned    route_len;
  int unsigned    track_len;
  bit             dropped;

  out_word_t      expected_results [$];
  pending_word_t  pending_words [$];
  int unsigned    mismatches;
  int unsigned    random_words;

  task automatic clear_track();
    tail_len  = 0;
    route_len = 0;
    track_len = 0;
    dropped   = 1'b0;
  endtask

  task automatic place_match(int unsigned pos);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = tail_len;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (tails[mid] < pos) lo = mid + 1;
      else hi = mid;
    end
    if (lo < tail_len) begin
      tails[lo] = pos;
    end else if (tail_len < MaxRoute) begin
      tails[tail_len] = pos;
      tail_len++;
    end
  endtask

  task automatic lcs_track_word(in_word_t w);
    out_word_t res;
    if (w.kind == KindRef) begin
      if (route_len < MaxRoute) begin
        route_ids[route_len] = w.node_id;
        route_len++;
      end else begin
        dropped = 1'b1;
      end
    end else begin
      if (track_len < 65535) track_len++;
      for (int p = int'(route_len) - 1; p >= 0; p--) begin
        if (route_ids[p] == w.node_id) place_match(unsigned'(p));
      end
    end
    if (w.last) begin
      res.lcs_length       = tail_len[LenW-1:0];
      res.reference_count  = route_len[LenW-1:0];
      res.trajectory_count = track_len[TrajW-1:0];
      res.overflow         = dropped;
      expected_results     = {expected_results, res};
      clear_track();
    end
  endtask

  task automatic report_mismatch(string what);
    if (mismatches < MaxPrinted) $display("tb: mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic int unsigned draw_wait();
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 12);
  endfunction

  task automatic add_word(logic kind, logic [IdW-1:0] id, logic last, bit quiet = 1'b0);
    pending_word_t pw;
    pw.word.kind    = kind;
    pw.word.node_id = id;
    pw.word.last    = last;
    pw.gap          = quiet ? 0 : draw_wait();
    pending_words   = {pending_words, pw};
  endtask

  // One well-formed comparison: a route, then a track whose IDs mostly come from the
  // same narrow alphabet. When mixed, kinds are interleaved and the last word may be a
  // reference word.
  task automatic add_sequence(int unsigned n_route, int unsigned n_track,
                              int unsigned alpha, bit mixed);
    int unsigned base;
    int unsigned total;
    logic        kind;
    logic [IdW-1:0] id;
    base = $urandom() & IdMax;
    case ($urandom_range(0, 9))
      0: base = 0;
      1: base = IdMax - alpha + 1;
      default: if (base > IdMax - alpha + 1) base = IdMax - alpha + 1;
    endcase
    total = n_route + n_track;
    for (int unsigned i = 0; i < total; i++) begin
      if (mixed) kind = $urandom_range(0, 1) ? KindTraj : KindRef;
      else kind = (i < n_route) ? KindRef : KindTraj;
      if ($urandom_range(0, 9) == 0) id = IdW'($urandom());
      else id = IdW'(base + $urandom_range(0, alpha - 1));
      add_word(kind, id, i == total - 1);
      random_words++;
    end
  endtask

  // Input driver: each queued word waits out its own gap before valid is raised.
  int unsigned wait_left = 0;
  bit          fresh_word = 1'b1;

  always @(posedge clk_i or negedge rst_ni) begin : drive_words
    pending_word_t nxt;
    bit            holding;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i  <= '0;
      wait_left  = 0;
      fresh_word = 1'b1;
    end else begin
      holding = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        lcs_track_word(in_word_i);
        holding    = 1'b0;
        fresh_word = 1'b1;
      end
      if (!holding) begin
        if (pending_words.size() == 0) begin
          in_valid_i <= 1'b0;
        end else begin
          if (fresh_word) begin
            wait_left  = pending_words[0].gap;
            fresh_word = 1'b0;
          end
          if (wait_left > 0) begin
            wait_left--;
            in_valid_i <= 1'b0;
          end else begin
            nxt = pending_words[0];
            pending_words.delete(0);
            in_valid_i <= 1'b1;
            in_word_i  <= nxt.word;
            fresh_word = 1'b1;
          end
        end
      end
    end
  end

  // Result monitor with random back-pressure, both after a result and out of the blue.
  int unsigned hold_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin : check_results
    out_word_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result word arrived with nothing expected");
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (out_word_o.lcs_length !== want.lcs_length)
            report_mismatch($sformatf("lcs_length got %0d want %0d",
                                      out_word_o.lcs_length, want.lcs_length));
          if (out_word_o.reference_count !== want.reference_count)
            report_mismatch($sformatf("reference_count got %0d want %0d",
                                      out_word_o.reference_count, want.reference_count));
          if (out_word_o.trajectory_count !== want.trajectory_count)
            report_mismatch($sformatf("trajectory_count got %0d want %0d",
                                      out_word_o.trajectory_count, want.trajectory_count));
          if (out_word_o.overflow !== want.overflow)
            report_mismatch($sformatf("overflow got %0b want %0b",
                                      out_word_o.overflow, want.overflow));
        end
        hold_left = draw_wait();
      end else if (hold_left == 0 && $urandom_range(0, 7) == 0) begin
        hold_left = draw_wait();
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog on cycles in which neither side moves a word.
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned seq_idx;
    int unsigned big_done;
    clear_track();
    mismatches   = 0;
    random_words = 0;

    // Directed: empty store with last on either kind.
    add_word(KindTraj, '0, 1'b1);
    add_word(KindRef, IdMax, 1'b1);
    // Extreme IDs, a reference after trajectory words, and last on a reference word.
    add_word(KindRef, '0, 1'b0);
    add_word(KindRef, IdMax, 1'b0);
    add_word(KindRef, '0, 1'b0);
    add_word(KindRef, 31'd5, 1'b0);
    add_word(KindTraj, IdMax, 1'b0);
    add_word(KindTraj, '0, 1'b0);
    add_word(KindTraj, 31'd5, 1'b0);
    add_word(KindRef, '0, 1'b0);
    add_word(KindTraj, '0, 1'b0);
    add_word(KindTraj, 31'h2AAAAAAA, 1'b0);
    add_word(KindRef, 31'h55555555, 1'b1);
    // Repeated ID: every position matches, yet the strict LIS stays at one.
    add_word(KindRef, 31'd3, 1'b0);
    add_word(KindRef, 31'd3, 1'b0);
    add_word(KindRef, 31'd3, 1'b0);
    add_word(KindTraj, 31'd3, 1'b1);

    // Random comparisons, mostly small, with a few that fill or overflow the store.
    seq_idx  = 0;
    big_done = 0;
    while (random_words < 1100) begin
      if (seq_idx % 25 == 7 && big_done < 3) begin
        case (big_done)
          0: add_sequence(MaxRoute, 2, 1, 1'b0);
          1: add_sequence($urandom_range(MaxRoute + 1, MaxRoute + 14), 4, 4, 1'b0);
          default: add_sequence($urandom_range(MaxRoute - 6, MaxRoute + 14), 3, 64, 1'b0);
        endcase
        big_done++;
      end else begin
        case ($urandom_range(0, 9))
          0: add_sequence(0, $urandom_range(1, 24), 1, 1'b1);
          1: add_sequence($urandom_range(17, 64), $urandom_range(1, 24),
                          $urandom_range(1, 16), 1'b0);
          2: add_sequence(0, $urandom_range(1, 24), $urandom_range(1, 1 << 20), 1'b1);
          default: add_sequence($urandom_range(0, 16), $urandom_range(1, 16),
                                $urandom_range(1, 8), 1'b0);
        endcase
      end
      seq_idx++;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i); while (pending_words.size() != 0 || in_valid_i);
    do @(posedge clk_i); while (expected_results.size() != 0);
    repeat (DrainWait) @(posedge clk_i);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: lcs_length_via_lis.f
rtl/lcsl_pkg.sv
rtl/lcsl_ram.sv
rtl/lcs_length_via_lis.sv
rtl/lcsl_checker.sv
verif/tb_lcs_length_via_lis.sv
